// File: hdl/bmmpq_pkg.sv
// Shared types for the bounded min/max priority queue.
// Holds action and commit codes, controller states and the command/status structs.
// No dependencies.
package bmmpq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_DEL_MIN = 2'd1,
		ACT_DEL_MAX = 2'd2,
		ACT_REMOVE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CM_NONE   = 2'd0,
		CM_INSERT = 2'd1,
		CM_SCAN   = 2'd2,
		CM_REMOVE = 2'd3
	} commit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_COMMIT,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_SCAN_COMMIT,
		ST_REM_COMMIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    pop;
		logic    scan_start;
		logic    scan_step;
		commit_t commit;
	} dp_cmd_t;

	typedef struct packed {
		action_t op;
		logic    stack_empty;
		logic    scan_last;
		logic    out_busy;
	} dp_status_t;

endpackage

// File: hdl/bounded_min_max_priority_queue.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  action, key, handle
// out       out_valid / out_stall result_handle, evicted
//
// Insert with a free handle and remove go straight to commit; delete-min, delete-max and
// insert into a full store first run the one-slot-a-cycle scan over the key memory's
// single read port.
// arst_n clears valid bits and control, sets fill count to CAPACITY; no stack clearing.
// A held result stalls only the commit; the next item is taken as soon as one is done.
// Top level of the bounded min/max priority queue; depends on bmmpq_pkg,
// bmmpq_ctrl and bmmpq_dp.
module bounded_min_max_priority_queue #(
	parameter  int CAPACITY = bmmpq_pkg::CAPACITY_DEF,
	localparam int HANDLE_W = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic signed [bmmpq_pkg::KEY_W-1:0] key,
	input  logic [HANDLE_W-1:0]                handle,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [HANDLE_W-1:0]                result_handle,
	output logic                               evicted
);
	import bmmpq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bmmpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bmmpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.action        (action),
		.key           (key),
		.handle        (handle),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_handle (result_handle),
		.evicted       (evicted)
	);

endmodule

// File: hdl/bmmpq_ctrl.sv
// Controller state machine for the bounded min/max priority queue.
// Sequences pop, slot scan and commit; depends on bmmpq_pkg.
module bmmpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bmmpq_pkg::dp_status_t status,
	output bmmpq_pkg::dp_cmd_t    cmd
);
	import bmmpq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (status.op == ACT_INSERT && !status.stack_empty) begin
					state_d = ST_INS_COMMIT;
				end else if (status.op == ACT_REMOVE) begin
					state_d = ST_REM_COMMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_SCAN_TAIL;
			end
			ST_SCAN_TAIL: begin
				state_d = ST_SCAN_COMMIT;
			end
			ST_INS_COMMIT, ST_SCAN_COMMIT, ST_REM_COMMIT: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_DISPATCH: begin
				if (status.op == ACT_INSERT && !status.stack_empty) begin
					cmd.pop = 1'b1;
				end else if (status.op != ACT_REMOVE) begin
					cmd.scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			// hold the commit until the output register can take the beat
			ST_INS_COMMIT: begin
				if (!status.out_busy) cmd.commit = CM_INSERT;
			end
			ST_SCAN_COMMIT: begin
				if (!status.out_busy) cmd.commit = CM_SCAN;
			end
			ST_REM_COMMIT: begin
				if (!status.out_busy) cmd.commit = CM_REMOVE;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: hdl/bmmpq_dp.sv
// Datapath for the bounded min/max priority queue: key memory, valid bits,
// free handle stack, extreme-key scan and output register. Depends on bmmpq_pkg.
module bmmpq_dp #(
	parameter  int CAPACITY = bmmpq_pkg::CAPACITY_DEF,
	localparam int HANDLE_W = $clog2(CAPACITY + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     action,
	input  logic signed [bmmpq_pkg::KEY_W-1:0] key,
	input  logic [HANDLE_W-1:0]            handle,
	input  bmmpq_pkg::dp_cmd_t             cmd,
	output bmmpq_pkg::dp_status_t          status,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [HANDLE_W-1:0]            result_handle,
	output logic                           evicted
);
	import bmmpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// captured item
	action_t                   op_q;
	logic signed [KEY_W-1:0]   key_q;
	logic [HANDLE_W-1:0]       handle_q;

	// stores
	logic signed [KEY_W-1:0]   key_mem [CAPACITY];
	logic [HANDLE_W-1:0]       stack_mem [CAPACITY];
	logic [CAPACITY-1:0]       valid_q;
	logic [HANDLE_W-1:0]       fc_q;
	logic [HANDLE_W-1:0]       lw_q;   // lowest fill count seen; entries below it are untouched

	// pop read stage
	logic [HANDLE_W-1:0]       stack_rd_s1;
	logic [HANDLE_W-1:0]       pop_rst_s1;
	logic                      pop_use_rst_s1;
	logic [HANDLE_W-1:0]       popped;
	logic [HANDLE_W-1:0]       fc_dec;

	// scan
	logic [AW-1:0]             scan_cnt_q;
	logic                      rd_v_s1;
	logic [AW-1:0]             rd_idx_s1;
	logic signed [KEY_W-1:0]   rd_key_s1;
	logic                      best_found_q;
	logic [AW-1:0]             best_idx_q;
	logic signed [KEY_W-1:0]   best_key_q;
	logic                      want_max;
	logic                      better;
	logic                      rd_hit;

	// commit
	logic [AW-1:0]             ins_idx;
	logic                      ins_ok;
	logic [HANDLE_W-1:0]       rem_dec;
	logic [AW-1:0]             rem_idx;
	logic                      rem_ok;
	logic [HANDLE_W-1:0]       best_h;
	logic                      key_wr_en;
	logic [AW-1:0]             key_wr_idx;
	logic                      set_en;
	logic                      rel_en;
	logic [AW-1:0]             rel_idx;
	logic                      push_en;
	logic [HANDLE_W-1:0]       res_h;
	logic                      res_ev;

	logic                      out_valid_q;
	logic [HANDLE_W-1:0]       result_handle_q;
	logic                      evicted_q;

	assign fc_dec = fc_q - HANDLE_W'(1);
	assign popped = pop_use_rst_s1 ? pop_rst_s1 : stack_rd_s1;

	assign want_max = (op_q != ACT_DEL_MIN);
	assign rd_hit   = rd_v_s1 && valid_q[rd_idx_s1];
	assign better   = want_max ? (rd_key_s1 > best_key_q) : (rd_key_s1 < best_key_q);

	assign ins_idx = fc_dec[AW-1:0] ^ fc_dec[AW-1:0] ^ AW'(popped - HANDLE_W'(1));
	assign ins_ok  = (popped != '0) && (popped <= HANDLE_W'(CAPACITY)) && !valid_q[ins_idx];
	assign rem_dec = handle_q - HANDLE_W'(1);
	assign rem_idx = rem_dec[AW-1:0];
	assign rem_ok  = (handle_q != '0) && (handle_q <= HANDLE_W'(CAPACITY)) && valid_q[rem_idx];
	assign best_h  = HANDLE_W'(best_idx_q) + HANDLE_W'(1);
	assign push_en = rel_en && (fc_q < HANDLE_W'(CAPACITY));

	always_comb begin
		key_wr_en  = 1'b0;
		key_wr_idx = best_idx_q;
		set_en     = 1'b0;
		rel_en     = 1'b0;
		rel_idx    = best_idx_q;
		res_h      = '0;
		res_ev     = 1'b0;
		case (cmd.commit)
			CM_INSERT: begin
				if (ins_ok) begin
					key_wr_en  = 1'b1;
					key_wr_idx = ins_idx;
					set_en     = 1'b1;
					res_h      = popped;
				end
			end
			CM_SCAN: begin
				if (op_q == ACT_INSERT) begin
					// full store: replace the largest only on a strictly smaller key
					if (best_found_q && key_q < best_key_q) begin
						key_wr_en = 1'b1;
						res_h     = best_h;
						res_ev    = 1'b1;
					end
				end else if (best_found_q) begin
					rel_en = 1'b1;
					res_h  = best_h;
				end
			end
			CM_REMOVE: begin
				if (rem_ok) begin
					rel_en  = 1'b1;
					rel_idx = rem_idx;
					res_h   = handle_q;
				end
			end
			default: begin
				res_h = '0;
			end
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= action_t'(action);
			key_q    <= key;
			handle_q <= handle;
		end
	end

	// key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (key_wr_en) key_mem[key_wr_idx] <= key_q;
		if (cmd.scan_step) rd_key_s1 <= key_mem[scan_cnt_q];
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (push_en) stack_mem[fc_q[AW-1:0]] <= HANDLE_W'(rel_idx) + HANDLE_W'(1);
		if (cmd.pop) begin
			stack_rd_s1    <= stack_mem[fc_dec[AW-1:0]];
			pop_rst_s1     <= fc_q;
			pop_use_rst_s1 <= (fc_q <= lw_q);
		end
	end

	// valid bits, fill count and low-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fc_q    <= HANDLE_W'(CAPACITY);
			lw_q    <= HANDLE_W'(CAPACITY);
		end else begin
			if (set_en) valid_q[key_wr_idx] <= 1'b1;
			if (rel_en) valid_q[rel_idx] <= 1'b0;
			if (cmd.pop) begin
				fc_q <= fc_dec;
				if (fc_dec < lw_q) lw_q <= fc_dec;
			end else if (push_en) begin
				fc_q <= fc_q + HANDLE_W'(1);
			end
		end
	end

	// scan: issue one slot read a cycle, compare each read in the cycle after it is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1      <= 1'b0;
			best_found_q <= 1'b0;
			scan_cnt_q   <= '0;
		end else begin
			rd_v_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				scan_cnt_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) scan_cnt_q <= scan_cnt_q + AW'(1);
				if (rd_hit && (!best_found_q || better)) best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) rd_idx_s1 <= scan_cnt_q;
		if (!cmd.scan_start && rd_hit && (!best_found_q || better)) begin
			best_idx_q <= rd_idx_s1;
			best_key_q <= rd_key_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit != CM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit != CM_NONE) begin
			result_handle_q <= res_h;
			evicted_q       <= res_ev;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_handle = result_handle_q;
	assign evicted       = evicted_q;

	assign status.op          = op_q;
	assign status.stack_empty = (fc_q == '0);
	assign status.scan_last   = (scan_cnt_q == AW'(CAPACITY - 1));
	assign status.out_busy    = out_valid_q && out_stall;

endmodule

// File: tb/bounded_min_max_priority_queue_test.sv
// Self-checking testbench for the bounded min/max priority queue: directed corner
// cases, a full-store eviction pass and random traffic against an in-bench predictor.
// Depends on bmmpq_pkg and bounded_min_max_priority_queue.
`timescale 1ns / 100ps

module bounded_min_max_priority_queue_test;
	import bmmpq_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int HANDLE_W     = $clog2(CAPACITY + 1);
	localparam int SCAN_CYCLES  = CAPACITY + 4;
	localparam int HANG_LIMIT   = 40 * SCAN_CYCLES;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_no;
		logic                evicted;
	} outcome_t;

	logic                        clk;
	logic                        arst_n        = 1'b0;
	logic                        in_valid      = 1'b0;
	logic                        in_stall;
	logic [1:0]                  action        = ACT_INSERT;
	logic signed [KEY_W-1:0]     key           = '0;
	logic [HANDLE_W-1:0]         handle        = '0;
	logic                        out_valid;
	logic                        out_stall     = 1'b0;
	logic [HANDLE_W-1:0]         result_handle;
	logic                        evicted;

	// predictor state: keys and occupancy by handle, LIFO of free handles
	logic signed [KEY_W-1:0]     key_of [1:CAPACITY];
	bit                          in_use [1:CAPACITY];
	int                          free_handles [0:CAPACITY-1];
	int                          free_depth;

	outcome_t                    pending_outcomes [$];
	int unsigned                 mismatch_count = 0;
	bit                          idle_on = 1'b1;
	int unsigned                 stall_run = 0;

	bounded_min_max_priority_queue #(.CAPACITY(CAPACITY)) i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void reset_queue_model();
		for (int n = 0; n < CAPACITY; n++) begin
			free_handles[n] = n + 1;
			in_use[n + 1]   = 1'b0;
		end
		free_depth = CAPACITY;
	endfunction

	// lowest handle wins ties; 0 when the store is empty
	function automatic int extreme_handle(bit want_max);
		int best = 0;
		for (int h = 1; h <= CAPACITY; h++)
			if (in_use[h] && (best == 0 ||
			    (want_max ? key_of[h] > key_of[best] : key_of[h] < key_of[best])))
				best = h;
		return best;
	endfunction

	function automatic void push_free(int slot);
		in_use[slot] = 1'b0;
		if (free_depth < CAPACITY) begin
			free_handles[free_depth] = slot;
			free_depth++;
		end
	endfunction

	function automatic outcome_t queue_outcome(action_t act, logic signed [KEY_W-1:0] k,
	                                           logic [HANDLE_W-1:0] h);
		outcome_t res = '0;
		int slot;
		case (act)
			ACT_INSERT: begin
				if (free_depth > 0) begin
					free_depth--;
					slot = free_handles[free_depth];
					if (!in_use[slot]) begin
						key_of[slot]  = k;
						in_use[slot]  = 1'b1;
						res.handle_no = HANDLE_W'(slot);
					end
				end else begin
					slot = extreme_handle(1'b1);
					if (slot != 0 && k < key_of[slot]) begin
						key_of[slot]  = k;
						res.handle_no = HANDLE_W'(slot);
						res.evicted   = 1'b1;
					end
				end
			end
			ACT_DEL_MIN, ACT_DEL_MAX: begin
				slot = extreme_handle(act == ACT_DEL_MAX);
				if (slot != 0) begin
					push_free(slot);
					res.handle_no = HANDLE_W'(slot);
				end
			end
			default: begin
				if (h >= 1 && h <= CAPACITY && in_use[h]) begin
					push_free(h);
					res.handle_no = h;
				end
			end
		endcase
		return res;
	endfunction

	function automatic logic signed [KEY_W-1:0] random_key();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: begin
				case ($urandom_range(0, 2))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000001;
					default: return 32'sh80000000;
				endcase
			end
			2: return $signed($urandom_range(0, 200)) - 100;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] random_handle();
		return HANDLE_W'($urandom_range(0, 2 ** HANDLE_W - 1));
	endfunction

	// mostly a handle that is in use, so removes actually hit
	function automatic logic [HANDLE_W-1:0] remove_target();
		int start;
		case ($urandom_range(0, 9))
			0: return random_handle();
			1: return HANDLE_W'($urandom_range(1, CAPACITY));
			default: begin
				start = $urandom_range(0, CAPACITY - 1);
				for (int n = 0; n < CAPACITY; n++)
					if (in_use[(start + n) % CAPACITY + 1])
						return HANDLE_W'((start + n) % CAPACITY + 1);
				return '0;
			end
		endcase
	endfunction

	task automatic send_beat(action_t act, logic signed [KEY_W-1:0] k,
	                         logic [HANDLE_W-1:0] h);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		handle   <= h;
		do @(posedge clk); while (in_stall);
		pending_outcomes.push_back(queue_outcome(act, k, h));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	task automatic test_empty_store();
		send_beat(ACT_DEL_MIN, 32'sh0, random_handle());
		send_beat(ACT_DEL_MAX, 32'sh0, random_handle());
		send_beat(ACT_REMOVE, 32'sh0, 7'd0);
		send_beat(ACT_REMOVE, 32'sh0, 7'd1);
		send_beat(ACT_REMOVE, 32'sh0, 7'd64);
		send_beat(ACT_REMOVE, 32'sh0, 7'd65);
		send_beat(ACT_REMOVE, 32'sh0, 7'd127);
	endtask

	task automatic test_key_extremes();
		send_beat(ACT_INSERT, 32'sh7FFFFFFF, 7'd0);
		send_beat(ACT_INSERT, 32'sh80000001, 7'd127);
		send_beat(ACT_INSERT, 32'sh80000000, 7'd64);
		send_beat(ACT_INSERT, 32'sh0, 7'd63);
		send_beat(ACT_INSERT, -32'sd1, 7'd0);
		send_beat(ACT_INSERT, 32'sd5, 7'd0);
		send_beat(ACT_INSERT, 32'sd5, 7'd0);
		send_beat(ACT_DEL_MAX, 32'sh0, 7'd0);
		// equal keys: lowest handle goes first
		send_beat(ACT_DEL_MAX, 32'sh0, 7'd0);
		send_beat(ACT_DEL_MIN, 32'sh0, 7'd0);
		send_beat(ACT_REMOVE, 32'sh0, 7'd61);
		send_beat(ACT_REMOVE, 32'sh0, 7'd61);
		send_beat(ACT_DEL_MIN, 32'sh0, 7'd0);
		send_beat(ACT_INSERT, 32'sd9, 7'd0);
		while (free_depth != CAPACITY)
			send_beat($urandom_range(0, 1) ? ACT_DEL_MIN : ACT_DEL_MAX, 32'sh0, 7'd0);
	endtask

	task automatic test_full_store();
		// narrow key spread so the largest key is often shared
		while (free_depth != 0)
			send_beat(ACT_INSERT, $signed($urandom_range(0, 40)) - 20, random_handle());
		wait_drained();
		send_beat(ACT_INSERT, key_of[extreme_handle(1'b1)], random_handle());
		send_beat(ACT_INSERT, 32'sh7FFFFFFF, random_handle());
		send_beat(ACT_INSERT, 32'sh80000000, random_handle());
		for (int n = 0; n < 12; n++)
			send_beat(ACT_INSERT, random_key(), random_handle());
		for (int n = 0; n < 4; n++) begin
			send_beat(ACT_DEL_MAX, random_key(), random_handle());
			send_beat(ACT_DEL_MIN, random_key(), random_handle());
		end
	endtask

	task automatic test_random_traffic(int unsigned items, bit with_idle);
		int unsigned grow_pct = 50;
		action_t act;
		for (int unsigned n = 0; n < items; n++) begin
			if (n % 75 == 0) begin
				grow_pct = $urandom_range(20, 85);
				idle_on  = with_idle && $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 99) < grow_pct)
				act = ACT_INSERT;
			else begin
				case ($urandom_range(0, 2))
					0: act = ACT_DEL_MIN;
					1: act = ACT_DEL_MAX;
					default: act = ACT_REMOVE;
				endcase
			end
			send_beat(act, random_key(),
			          act == ACT_REMOVE ? remove_target() : random_handle());
		end
	endtask

	always @(posedge clk) begin
		if (stall_run > 0)
			stall_run--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_run = $urandom_range(1, 8);
		out_stall <= stall_run > 0;
	end

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0)
				note_mismatch($sformatf("result with none expected: handle %0d evicted %0b",
				                        result_handle, evicted));
			else begin
				want = pending_outcomes.pop_front();
				if (result_handle !== want.handle_no || evicted !== want.evicted)
					note_mismatch($sformatf(
						"expected handle %0d evicted %0b, got handle %0d evicted %0b",
						want.handle_no, want.evicted, result_handle, evicted));
			end
		end
	end

	// bail out when no beat moves on either side for too long
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		reset_queue_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_key_extremes();
		test_full_store();
		test_random_traffic(460, 1'b1);
		test_random_traffic(60, 1'b0);
		idle_on = 1'b0;
		wait_drained();
		repeat (2 * SCAN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
